// ===== rtl/heightfield_vertex_normal_assert.svh =====
// assertion macros for the vertex normal block
`ifndef HEIGHTFIELD_VERTEX_NORMAL_ASSERT_SVH
`define HEIGHTFIELD_VERTEX_NORMAL_ASSERT_SVH

`ifndef ASSERT_OFF
`define HVN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vertex normal assertion failed");
`define HVN_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("vertex normal assertion failed");
`else
`define HVN_ASSERT(lbl, clk, rst, prop)
`define HVN_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

// ===== rtl/hvn_pkg.sv =====
package hvn_pkg;

   // defaults for the top level parameters
   localparam int MAX_GRID_SIDE_DEF = 4096;
   localparam int HEIGHT_BITS_DEF   = 16;

   // fixed field widths
   localparam int COORD_W = 12;
   localparam int GRID_W  = 13;
   localparam int STEP_W  = 16;
   localparam int OUT_W   = 16;

   // normalisation datapath
   localparam int MAG_CAP = 31;   // reduced magnitudes stay below 2^31
   localparam int SQ_W    = 64;   // sum of three squares
   localparam int PW      = 81;   // sum of squares times odd trial value
   localparam int RW      = 100;  // residual of the rounding test
   localparam int KW      = 15;   // unit magnitude 0..16384
   localparam int DIGITS  = 15;

   typedef enum logic [2:0] {
      REG_GRID_WIDTH,
      REG_GRID_HEIGHT,
      REG_STEP_X,
      REG_STEP_Y,
      REG_HEIGHT_SCALE
   } reg_index_type;

   // state carried through the digit recurrence
   typedef struct packed {
      logic                 zero;
      logic [2:0]           neg;
      logic [SQ_W-1:0]      sum_sq;
      logic [2:0][RW-1:0]   rem;
      logic [2:0][PW-1:0]   prod;
      logic [2:0][KW-1:0]   k;
   } digit_type;

endpackage

// ===== rtl/hvn_digit_stage.sv =====
// one result bit of the rounded unit magnitude for all three components
module hvn_digit_stage
   import hvn_pkg::*;
#(
   parameter int J = 0
) (
   input  logic      clock,
   input  logic      load,
   input  digit_type d_in,
   output digit_type d_out
);

   digit_type d_ff, d_in_nxt;

   // trial k + 2^J: residual drops by ((2k-1)*S + S*2^J) * 2^(J+2)
   always_comb begin
      logic signed [RW-1:0] pe, se, inc, rnew;
      d_in_nxt = d_in;
      for (int c = 0; c < 3; c++) begin
         pe   = RW'($signed(d_in.prod[c]));
         se   = RW'(d_in.sum_sq);
         inc  = (pe + (se <<< J)) <<< (J + 2);
         rnew = $signed(d_in.rem[c]) - inc;
         if (!rnew[RW-1]) begin
            d_in_nxt.rem[c]  = rnew;
            d_in_nxt.prod[c] = d_in.prod[c] + (PW'(d_in.sum_sq) << (J + 1));
            d_in_nxt.k[c]    = d_in.k[c] | (KW'(1) << J);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         d_ff <= d_in_nxt;
      end
   end

   assign d_out = d_ff;

endmodule

// ===== rtl/heightfield_vertex_normal.sv =====
// pipeline: 23 register stages from request to result
// throughput: one request per cycle when nothing stalls, set by a fully
// pipelined datapath with one bit of each unit magnitude resolved per stage
// a stall holds the last stage and each full stage behind it; empty ones keep filling
// reset: synchronous, clears every stage valid and sets the registers to 256
module heightfield_vertex_normal
   import hvn_pkg::*;
#(
   parameter int MAX_GRID_SIDE = MAX_GRID_SIDE_DEF,
   parameter int HEIGHT_BITS   = HEIGHT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [COORD_W-1:0]            req_col,
   input  logic [COORD_W-1:0]            req_row,
   input  logic signed [HEIGHT_BITS-1:0] req_h_center,
   input  logic signed [HEIGHT_BITS-1:0] req_h_left,
   input  logic signed [HEIGHT_BITS-1:0] req_h_right,
   input  logic signed [HEIGHT_BITS-1:0] req_h_below,
   input  logic signed [HEIGHT_BITS-1:0] req_h_above,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_W-1:0]       rsp_normal_x,
   output logic signed [OUT_W-1:0]       rsp_normal_y,
   output logic signed [OUT_W-1:0]       rsp_normal_z,
   output logic                          rsp_zero_normal,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [4:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

`include "heightfield_vertex_normal_assert.svh"

   localparam int GSW   = $clog2(MAX_GRID_SIDE + 1);
   localparam int CW    = ((GSW > GRID_W) ? GSW : GRID_W) + 1;
   localparam int DW    = HEIGHT_BITS + 1;
   localparam int SAW   = HEIGHT_BITS + 3;
   localparam int PAW   = SAW + STEP_W + 1;
   localparam int PNW   = STEP_W + 3;
   localparam int MW    = PAW + STEP_W + 1;
   localparam int SHW   = $clog2(MW - MAG_CAP + 2);
   localparam int NST   = 7 + DIGITS + 1;
   localparam int OUT_S = NST - 1;

   // configuration registers
   logic [GRID_W-1:0] grid_width_ff, grid_height_ff;
   logic [STEP_W-1:0] step_x_ff, step_y_ff, height_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= GRID_W'(256);
         grid_height_ff  <= GRID_W'(256);
         step_x_ff       <= STEP_W'(256);
         step_y_ff       <= STEP_W'(256);
         height_scale_ff <= STEP_W'(256);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[4:2])
            REG_GRID_WIDTH:   grid_width_ff   <= csr_pwdata[GRID_W-1:0];
            REG_GRID_HEIGHT:  grid_height_ff  <= csr_pwdata[GRID_W-1:0];
            REG_STEP_X:       step_x_ff       <= csr_pwdata[STEP_W-1:0];
            REG_STEP_Y:       step_y_ff       <= csr_pwdata[STEP_W-1:0];
            REG_HEIGHT_SCALE: height_scale_ff <= csr_pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_paddr[4:2])
         REG_GRID_WIDTH:   csr_prdata = 32'(grid_width_ff);
         REG_GRID_HEIGHT:  csr_prdata = 32'(grid_height_ff);
         REG_STEP_X:       csr_prdata = 32'(step_x_ff);
         REG_STEP_Y:       csr_prdata = 32'(step_y_ff);
         REG_HEIGHT_SCALE: csr_prdata = 32'(height_scale_ff);
         default:          csr_prdata = 32'd0;
      endcase
   end
   assign csr_pready = 1'b1;

   // stage valids and ready chain
   logic [NST-1:0] vld_ff;
   logic [NST:0]   ready;

   always_comb begin
      ready[NST] = !rsp_stall;
      for (int i = NST - 1; i >= 0; i--) begin
         ready[i] = !vld_ff[i] || ready[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (ready[i]) begin
               vld_ff[i] <= (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   assign req_stall = !ready[0];

   // grid side clamp and quadrant sums
   function automatic logic [CW-1:0] side_of(input logic [GRID_W-1:0] r);
      logic [CW-1:0] v;
      v = CW'(r);
      if (v == '0) begin
         v = CW'(1);
      end else if (v > CW'(MAX_GRID_SIDE)) begin
         v = CW'(MAX_GRID_SIDE);
      end
      return v;
   endfunction

   logic signed [SAW-1:0] sa_ff, sb_ff;
   logic [2:0]            n_ff;

   always_comb begin : quad
      logic right, left, up, down;
      logic signed [DW-1:0] dxr, dxl, dya, dyb;
      right = (CW'(req_col) + CW'(1)) < side_of(grid_width_ff);
      left  = req_col != '0;
      up    = (CW'(req_row) + CW'(1)) < side_of(grid_height_ff);
      down  = req_row != '0;
      dxr = DW'(req_h_right) - DW'(req_h_center);
      dxl = DW'(req_h_center) - DW'(req_h_left);
      dya = DW'(req_h_above) - DW'(req_h_center);
      dyb = DW'(req_h_center) - DW'(req_h_below);
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         sa_ff <= ((quad.right && quad.up)   ? SAW'(quad.dxr) : SAW'(0))
                + ((quad.left  && quad.up)   ? SAW'(quad.dxl) : SAW'(0))
                + ((quad.right && quad.down) ? SAW'(quad.dxr) : SAW'(0))
                + ((quad.left  && quad.down) ? SAW'(quad.dxl) : SAW'(0));
         sb_ff <= ((quad.right && quad.up)   ? SAW'(quad.dya) : SAW'(0))
                + ((quad.left  && quad.up)   ? SAW'(quad.dya) : SAW'(0))
                + ((quad.right && quad.down) ? SAW'(quad.dyb) : SAW'(0))
                + ((quad.left  && quad.down) ? SAW'(quad.dyb) : SAW'(0));
         n_ff  <= 3'(quad.right && quad.up) + 3'(quad.left && quad.up)
                + 3'(quad.right && quad.down) + 3'(quad.left && quad.down);
      end
   end

   // first products: height scale and x spacing
   logic signed [PAW-1:0] pa_ff, pb_ff;
   logic [PNW-1:0]        pn_ff;

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         pa_ff <= PAW'(sa_ff) * PAW'($signed({1'b0, height_scale_ff}));
         pb_ff <= PAW'(sb_ff) * PAW'($signed({1'b0, height_scale_ff}));
         pn_ff <= PNW'(n_ff) * PNW'(step_x_ff);
      end
   end

   // second products, split into sign and magnitude
   logic [2:0]           neg_c_ff;
   logic [2:0][MW-1:0]   mag_c_ff;

   always_comb begin : prod2
      logic signed [MW-1:0] qa, qb;
      qa = MW'(pa_ff) * MW'($signed({1'b0, step_y_ff}));
      qb = MW'(pb_ff) * MW'($signed({1'b0, step_x_ff}));
   end

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         neg_c_ff[0] <= prod2.qa > 0;
         neg_c_ff[1] <= prod2.qb > 0;
         neg_c_ff[2] <= 1'b0;
         mag_c_ff[0] <= prod2.qa[MW-1] ? MW'(-prod2.qa) : MW'(prod2.qa);
         mag_c_ff[1] <= prod2.qb[MW-1] ? MW'(-prod2.qb) : MW'(prod2.qb);
         mag_c_ff[2] <= MW'(pn_ff) * MW'(step_y_ff);
      end
   end

   // reduction shift from the leading one of the largest magnitude
   logic [2:0]         neg_d_ff;
   logic [2:0][MW-1:0] mag_d_ff;
   logic [SHW-1:0]     shift_d_ff;

   always_comb begin : lead
      logic [MW-1:0]  any_m;
      logic [SHW-1:0] s;
      any_m = mag_c_ff[0] | mag_c_ff[1] | mag_c_ff[2];
      s = '0;
      for (int i = MAG_CAP; i < MW; i++) begin
         if (any_m[i]) begin
            s = SHW'(i - MAG_CAP + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         neg_d_ff   <= neg_c_ff;
         mag_d_ff   <= mag_c_ff;
         shift_d_ff <= lead.s;
      end
   end

   // reduced magnitudes
   logic [2:0]              neg_e_ff;
   logic [2:0][MAG_CAP-1:0] mag_e_ff;

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         neg_e_ff <= neg_d_ff;
         for (int c = 0; c < 3; c++) begin
            mag_e_ff[c] <= MAG_CAP'(mag_d_ff[c] >> shift_d_ff);
         end
      end
   end

   // squares
   logic [2:0]                neg_f_ff;
   logic [2:0][2*MAG_CAP-1:0] sq_f_ff;

   always_ff @(posedge clock) begin
      if (ready[5]) begin
         neg_f_ff <= neg_e_ff;
         for (int c = 0; c < 3; c++) begin
            sq_f_ff[c] <= (2*MAG_CAP)'(mag_e_ff[c]) * (2*MAG_CAP)'(mag_e_ff[c]);
         end
      end
   end

   // sum of squares and start of the recurrence with k = 0
   digit_type dig [0:DIGITS];
   digit_type dig_g_ff;

   always_comb begin : seed
      logic [SQ_W-1:0] s;
      s = SQ_W'(sq_f_ff[0]) + SQ_W'(sq_f_ff[1]) + SQ_W'(sq_f_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (ready[6]) begin
         dig_g_ff.zero   <= seed.s == '0;
         dig_g_ff.neg    <= neg_f_ff;
         dig_g_ff.sum_sq <= seed.s;
         for (int c = 0; c < 3; c++) begin
            dig_g_ff.rem[c]  <= (RW'(sq_f_ff[c]) << 30) - RW'(seed.s);
            dig_g_ff.prod[c] <= PW'(0) - PW'(seed.s);
            dig_g_ff.k[c]    <= '0;
         end
      end
   end

   assign dig[0] = dig_g_ff;

   // one magnitude bit per stage, most significant first
   for (genvar g = 0; g < DIGITS; g++) begin : g_digit
      hvn_digit_stage #(
         .J (DIGITS - 1 - g)
      ) u_digit (
         .clock (clock),
         .load  (ready[7+g]),
         .d_in  (dig[g]),
         .d_out (dig[g+1])
      );
   end

   // signed outputs
   logic signed [OUT_W-1:0] nx_ff, ny_ff, nz_ff;
   logic                    zero_ff;

   function automatic logic signed [OUT_W-1:0] apply_sign(input logic n,
                                                          input logic [KW-1:0] k);
      return n ? OUT_W'(0) - OUT_W'(k) : OUT_W'(k);
   endfunction

   always_ff @(posedge clock) begin
      if (ready[OUT_S]) begin
         zero_ff <= dig[DIGITS].zero;
         nx_ff   <= dig[DIGITS].zero ? '0 : apply_sign(dig[DIGITS].neg[0], dig[DIGITS].k[0]);
         ny_ff   <= dig[DIGITS].zero ? '0 : apply_sign(dig[DIGITS].neg[1], dig[DIGITS].k[1]);
         nz_ff   <= dig[DIGITS].zero ? '0 : apply_sign(dig[DIGITS].neg[2], dig[DIGITS].k[2]);
      end
   end

   assign rsp_valid       = vld_ff[OUT_S];
   assign rsp_normal_x    = nx_ff;
   assign rsp_normal_y    = ny_ff;
   assign rsp_normal_z    = nz_ff;
   assign rsp_zero_normal = zero_ff;

   // checks
   `HVN_ASSERT(a_zero_vec, clock, reset, (rsp_valid && rsp_zero_normal) |-> (rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0))
   `HVN_ASSERT(a_z_nonneg, clock, reset, rsp_valid |-> !rsp_normal_z[OUT_W-1])
   `HVN_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall))
   `HVN_ASSERT_NEXT(a_last_move, clock, reset, vld_ff[OUT_S-1] && ready[OUT_S], rsp_valid)

endmodule
